// ----- rtl/core/hep_pkg.sv -----
// ----------------------------------------------------------------------------
// hep_pkg
// Shared types, command codes and sizing helpers for the static-table
// Huffman encoder and byte packer.
// ----------------------------------------------------------------------------
package hep_pkg;

    // Default sizing
    localparam int MAX_CODE_LEN_DEF  = 16;
    localparam int ALPHABET_SIZE_DEF = 256;

    // Width of the code_value field on the input request
    localparam int CODE_FIELD_W = 16;

    // Fixed field widths of the request and result
    localparam int SYM_W   = 8;
    localparam int CLEN_W  = 5;
    localparam int BYTE_W  = 8;
    localparam int TOTAL_W = 32;
    localparam int PEND_W  = 7;
    localparam int PCNT_W  = 3;

    // Command codes (s_axis_tuser)
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // Stored code width: the code field limits MAX_CODE_LEN
    function automatic int code_bits(input int max_len);
        return (max_len < CODE_FIELD_W) ? max_len : CODE_FIELD_W;
    endfunction

    // Lookup stage status handed from the table to the packer
    typedef struct packed {
        logic       valid;
        logic [1:0] cmd;
        logic       known;
    } lookup_t;

    // One result request
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               unknown_symbol;
        logic               last;
        logic [TOTAL_W-1:0] total_bits;
    } res_t;

endpackage

// ----- rtl/core/huffman_encoder_bit_packer.sv -----
// ----------------------------------------------------------------------------
// huffman_encoder_bit_packer
// Static-table Huffman encoder with a byte packer.
//
// Requests enter on the s_axis channel; tuser carries the command (load a
// table entry, encode a symbol, finish the run). Results leave on m_axis:
// packed bytes, the earliest code bit in the MSB, an unknown-symbol flag,
// tlast on the finish result and on unknown-symbol results, and the coded
// bit count of the run on the finish result.
// A request's code is read from the code RAM into the lookup stage and is
// then packed into the output buffer, from which its first result is taken.
// Throughput: one request per cycle while results drain; a request that
// yields two bytes holds the packer until the single output port has
// drained both entries of the output buffer. Loads are taken at one per
// cycle; finishes wait, like encodes, for the output buffer to empty.
// Reset clears the valid bits of the code table, the pending bits and the
// bit count; no clearing pass is needed and requests are taken at once.
// When m_axis_tready is low, results wait in the output buffer; the lookup
// stage then holds and s_axis_tready drops until space frees up.
// ----------------------------------------------------------------------------
module huffman_encoder_bit_packer #(
    parameter int MAX_CODE_LEN  = hep_pkg::MAX_CODE_LEN_DEF,
    parameter int ALPHABET_SIZE = hep_pkg::ALPHABET_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // symbol[7:0], code_value[23:8],
                                        // code_length[28:24], zero[31:29]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_byte[7:0], total_bits[39:8]
    output logic [1:0]  m_axis_tuser,   // byte_valid[0], unknown_symbol[1]
    output logic        m_axis_tlast    // last
);

    localparam int CODE_W = hep_pkg::code_bits(MAX_CODE_LEN);
    localparam int LEN_W  = $clog2(CODE_W + 1);

    hep_pkg::lookup_t   lookup;
    logic [CODE_W-1:0]  lk_code;
    logic [LEN_W-1:0]   lk_len;
    logic               take;
    hep_pkg::res_t      res;

    // Code table and lookup stage
    hep_table #(
        .MAX_CODE_LEN  (MAX_CODE_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .CODE_W        (CODE_W),
        .LEN_W         (LEN_W)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .cmd         (s_axis_tuser),
        .symbol      (s_axis_tdata[7:0]),
        .code_value  (s_axis_tdata[23:8]),
        .code_length (s_axis_tdata[28:24]),
        .take        (take),
        .lookup      (lookup),
        .lk_code     (lk_code),
        .lk_len      (lk_len)
    );

    // Bit packer and output buffer
    hep_pack #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .CODE_W       (CODE_W),
        .LEN_W        (LEN_W)
    ) u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookup    (lookup),
        .lk_code   (lk_code),
        .lk_len    (lk_len),
        .take      (take),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {res.total_bits, res.out_byte};
    assign m_axis_tuser = {res.unknown_symbol, res.byte_valid};
    assign m_axis_tlast = res.last;

endmodule

// ----- rtl/core/hep_ram.sv -----
// ----------------------------------------------------------------------------
// hep_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while re is low.
// ----------------------------------------------------------------------------
module hep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/hep_table.sv -----
// ----------------------------------------------------------------------------
// hep_table
// Code table front end: accepts requests, writes loads into the code RAM,
// reads the code for encodes and keeps the per-symbol valid bits. Holds the
// lookup stage until the packer takes it.
// ----------------------------------------------------------------------------
module hep_table #(
    parameter int MAX_CODE_LEN  = hep_pkg::MAX_CODE_LEN_DEF,
    parameter int ALPHABET_SIZE = hep_pkg::ALPHABET_SIZE_DEF,
    parameter int CODE_W        = hep_pkg::code_bits(MAX_CODE_LEN),
    parameter int LEN_W         = $clog2(CODE_W + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request side
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [hep_pkg::SYM_W-1:0]   symbol,
    input  logic [hep_pkg::CODE_FIELD_W-1:0] code_value,
    input  logic [hep_pkg::CLEN_W-1:0]  code_length,
    // lookup stage toward the packer
    input  logic                        take,
    output hep_pkg::lookup_t            lookup,
    output logic [CODE_W-1:0]           lk_code,
    output logic [LEN_W-1:0]            lk_len
);

    localparam int AW = $clog2(ALPHABET_SIZE);

    logic                     accept;
    logic                     in_range;
    logic [AW-1:0]            idx;
    logic [LEN_W-1:0]         len_sat;
    logic [CODE_W:0]          one_sh;
    logic [CODE_W-1:0]        code_mask;
    logic                     we;
    logic [CODE_W+LEN_W-1:0]  rdata;

    logic [ALPHABET_SIZE-1:0] entry_valid_reg;
    logic [ALPHABET_SIZE-1:0] entry_valid_next;
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [1:0]               s1_cmd_reg;
    logic [1:0]               s1_cmd_next;
    logic                     s1_known_reg;
    logic                     s1_known_next;

    assign in_ready = !s1_valid_reg || take;
    assign accept   = in_valid && in_ready;
    assign in_range = ({1'b0, symbol} < 9'(ALPHABET_SIZE));
    assign idx      = symbol[AW-1:0];

    // Saturate the length to the stored code width and mask stray code bits
    always_comb
    begin
        if (code_length > hep_pkg::CLEN_W'(CODE_W))
        begin
            len_sat = LEN_W'(CODE_W);
        end
        else
        begin
            len_sat = LEN_W'(code_length);
        end
        one_sh    = (CODE_W + 1)'(1) << len_sat;
        code_mask = CODE_W'(one_sh - 1'b1);
    end

    assign we = accept && (cmd == hep_pkg::CMD_LOAD) && in_range;

    hep_ram #(
        .WIDTH (CODE_W + LEN_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_code_ram (
        .clk   (clk),
        .we    (we),
        .waddr (idx),
        .wdata ({len_sat, code_value[CODE_W-1:0] & code_mask}),
        .re    (accept),
        .raddr (idx),
        .rdata (rdata)
    );

    assign lk_code = rdata[CODE_W-1:0];
    assign lk_len  = rdata[CODE_W+LEN_W-1:CODE_W];

    // Valid bits and lookup stage next state
    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        s1_valid_next    = s1_valid_reg;
        s1_cmd_next      = s1_cmd_reg;
        s1_known_next    = s1_known_reg;
        if (we)
        begin
            entry_valid_next[idx] = 1'b1;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_cmd_next   = cmd;
            s1_known_next = in_range && entry_valid_reg[idx];
        end
        else if (take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            s1_valid_reg    <= 1'b0;
            s1_cmd_reg      <= hep_pkg::CMD_LOAD;
            s1_known_reg    <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            s1_valid_reg    <= s1_valid_next;
            s1_cmd_reg      <= s1_cmd_next;
            s1_known_reg    <= s1_known_next;
        end
    end

    assign lookup.valid = s1_valid_reg;
    assign lookup.cmd   = s1_cmd_reg;
    assign lookup.known = s1_known_reg;

    // Assertions
    a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> s1_valid_reg)
        else $error("packer took an empty lookup stage");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> entry_valid_reg[$past(idx)])
        else $error("loaded entry not marked valid");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("request blocked with empty lookup stage");

endmodule

// ----- rtl/core/hep_pack.sv -----
// ----------------------------------------------------------------------------
// hep_pack
// Bit packer: appends the looked-up code to the pending bits, splits off
// whole bytes, handles finish and unknown symbols, and holds up to two
// result requests in an output buffer.
// ----------------------------------------------------------------------------
module hep_pack #(
    parameter int MAX_CODE_LEN = hep_pkg::MAX_CODE_LEN_DEF,
    parameter int CODE_W       = hep_pkg::code_bits(MAX_CODE_LEN),
    parameter int LEN_W        = $clog2(CODE_W + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // lookup stage
    input  hep_pkg::lookup_t             lookup,
    input  logic [CODE_W-1:0]            lk_code,
    input  logic [LEN_W-1:0]             lk_len,
    output logic                         take,
    // result side
    output logic                         res_valid,
    input  logic                         res_ready,
    output hep_pkg::res_t                res
);

    localparam int ACC_W = hep_pkg::PEND_W + CODE_W;
    localparam int N_W   = $clog2(ACC_W + 1);

    logic [hep_pkg::PEND_W-1:0]  pend_reg;
    logic [hep_pkg::PEND_W-1:0]  pend_next;
    logic [hep_pkg::PCNT_W-1:0]  pcnt_reg;
    logic [hep_pkg::PCNT_W-1:0]  pcnt_next;
    logic [hep_pkg::TOTAL_W-1:0] total_reg;
    logic [hep_pkg::TOTAL_W-1:0] total_next;
    logic [1:0]                  em_cnt_reg;
    logic [1:0]                  em_cnt_next;
    hep_pkg::res_t               em0_reg;
    hep_pkg::res_t               em0_next;
    hep_pkg::res_t               em1_reg;
    hep_pkg::res_t               em1_next;

    logic [ACC_W-1:0]            acc;
    logic [N_W-1:0]              n;
    logic [hep_pkg::PCNT_W-1:0]  nrem;
    logic [7:0]                  rem_mask;
    logic [hep_pkg::BYTE_W-1:0]  b0;
    logic [hep_pkg::BYTE_W-1:0]  b1;
    logic [hep_pkg::TOTAL_W:0]   total_sum;
    logic [hep_pkg::TOTAL_W-1:0] total_sat;
    logic [hep_pkg::BYTE_W-1:0]  fin_byte;
    logic [15:0]                 fin_wide;
    logic [1:0]                  nres;
    hep_pkg::res_t               r0;
    hep_pkg::res_t               r1;
    logic                        pop;
    logic [1:0]                  cnt_after_pop;

    // Append the code behind the pending bits
    assign acc = (ACC_W'(pend_reg) << lk_len) | ACC_W'(lk_code);
    assign n   = N_W'(pcnt_reg) + N_W'(lk_len);

    // Saturating bit count
    assign total_sum = {1'b0, total_reg} + (hep_pkg::TOTAL_W + 1)'(lk_len);
    assign total_sat = total_sum[hep_pkg::TOTAL_W] ? '1
                                                   : total_sum[hep_pkg::TOTAL_W-1:0];

    // Finish byte: pending bits moved up against the MSB
    assign fin_wide = 16'(pend_reg) << (4'd8 - {1'b0, pcnt_reg});
    assign fin_byte = fin_wide[7:0];

    // Byte split of the accumulator
    always_comb
    begin
        b0   = '0;
        b1   = '0;
        nrem = hep_pkg::PCNT_W'(n);
        if (n >= N_W'(16))
        begin
            b0   = hep_pkg::BYTE_W'(acc >> (n - N_W'(8)));
            b1   = hep_pkg::BYTE_W'(acc >> (n - N_W'(16)));
            nrem = hep_pkg::PCNT_W'(n - N_W'(16));
        end
        else if (n >= N_W'(8))
        begin
            b0   = hep_pkg::BYTE_W'(acc >> (n - N_W'(8)));
            nrem = hep_pkg::PCNT_W'(n - N_W'(8));
        end
        rem_mask = (8'd1 << nrem) - 8'd1;
    end

    // Results and state update for the item in the lookup stage
    always_comb
    begin
        nres       = 2'd0;
        r0         = '0;
        r1         = '0;
        pend_next  = pend_reg;
        pcnt_next  = pcnt_reg;
        total_next = total_reg;
        case (lookup.cmd)
            hep_pkg::CMD_ENCODE:
            begin
                if (!lookup.known)
                begin
                    nres             = 2'd1;
                    r0.unknown_symbol = 1'b1;
                    r0.last           = 1'b1;
                end
                else
                begin
                    if (n >= N_W'(16))
                    begin
                        nres = 2'd2;
                    end
                    else if (n >= N_W'(8))
                    begin
                        nres = 2'd1;
                    end
                    r0.out_byte   = b0;
                    r0.byte_valid = 1'b1;
                    r1.out_byte   = b1;
                    r1.byte_valid = 1'b1;
                    pend_next     = acc[hep_pkg::PEND_W-1:0] & rem_mask[hep_pkg::PEND_W-1:0];
                    pcnt_next     = nrem;
                    total_next    = total_sat;
                end
            end
            hep_pkg::CMD_FINISH:
            begin
                nres          = 2'd1;
                r0.last       = 1'b1;
                r0.total_bits = total_reg;
                if (pcnt_reg != '0)
                begin
                    r0.out_byte   = fin_byte;
                    r0.byte_valid = 1'b1;
                end
                pend_next  = '0;
                pcnt_next  = '0;
                total_next = '0;
            end
            default:
            begin
                nres = 2'd0;
            end
        endcase
    end

    // Output buffer: pop the head, then accept a new batch into an empty buffer
    assign pop           = res_valid && res_ready;
    assign cnt_after_pop = em_cnt_reg - {1'b0, pop};
    assign take          = lookup.valid && ((nres == 2'd0) || (cnt_after_pop == 2'd0));

    always_comb
    begin
        em_cnt_next = cnt_after_pop;
        em0_next    = pop ? em1_reg : em0_reg;
        em1_next    = em1_reg;
        if (take && (nres != 2'd0))
        begin
            em_cnt_next = nres;
            em0_next    = r0;
            em1_next    = r1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= '0;
            pcnt_reg   <= '0;
            total_reg  <= '0;
            em_cnt_reg <= 2'd0;
        end
        else
        begin
            em_cnt_reg <= em_cnt_next;
            if (take)
            begin
                pend_reg  <= pend_next;
                pcnt_reg  <= pcnt_next;
                total_reg <= total_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        em0_reg <= em0_next;
        em1_reg <= em1_next;
    end

    assign res_valid = (em_cnt_reg != 2'd0);
    assign res       = em0_reg;

    // Assertions
    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        em_cnt_reg != 2'd3)
        else $error("output buffer overflow");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && (lookup.cmd == hep_pkg::CMD_FINISH) |=> (pcnt_reg == '0) && (total_reg == '0))
        else $error("finish did not clear the run state");

    a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
        take && (lookup.cmd != hep_pkg::CMD_FINISH) |=> total_reg >= $past(total_reg))
        else $error("bit count went down within a run");

    a_unknown_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.unknown_symbol |-> res.last && !res.byte_valid)
        else $error("malformed unknown-symbol result");

endmodule

// ----- tb/tb_huffman_encoder_bit_packer.sv -----
// ----------------------------------------------------------------------------
// tb_huffman_encoder_bit_packer
// Self-checking bench for the static-table Huffman encoder and byte packer.
// A clocked driver feeds load, encode, finish and unused-command requests
// from a queue filled up front; a scoreboard model of the code table and the
// bit accumulator predicts every result, and a clocked monitor compares each
// result against the oldest prediction. Both channels stall at random, with
// a quiet window and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_huffman_encoder_bit_packer;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int LEN_LIMIT = (hep_pkg::MAX_CODE_LEN_DEF < hep_pkg::CODE_FIELD_W) ?
                               hep_pkg::MAX_CODE_LEN_DEF : hep_pkg::CODE_FIELD_W;
    localparam int RANDOM_REQS = 1950;
    localparam int HOLD_START  = 1200;   // output hold-off window
    localparam int HOLD_LEN    = 400;
    localparam int QUIET_START = 2000;   // no random idling on either side
    localparam int QUIET_END   = 3000;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  sym;
        logic [15:0] cval;
        logic [4:0]  clen;
    } hep_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // symbol[7:0], code_value[23:8],
                                      // code_length[28:24], zero[31:29]
    logic [1:0]  s_axis_tuser = '0;   // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // out_byte[7:0], total_bits[39:8]
    logic [1:0]  m_axis_tuser;        // byte_valid[0], unknown_symbol[1]
    logic        m_axis_tlast;

    // Stimulus and scoreboard storage
    hep_req_t       stim_q[$];
    hep_req_t       cur_req;
    hep_pkg::res_t  coded_results_q[$];
    hep_pkg::res_t  exp_res;
    hep_pkg::res_t  got_res;

    // Scoreboard copy of the code table and the run accumulator
    logic [15:0] tbl_code[256];
    int unsigned tbl_len[256];
    bit          tbl_valid[256];
    logic [6:0]  run_bits = '0;
    int unsigned run_count = 0;
    logic [31:0] run_total = '0;

    // Generator bookkeeping: which symbols have a code
    bit          gen_loaded[256];
    logic [7:0]  gen_syms[$];
    int          gen_count = 0;

    int unsigned cycle = 0;
    int unsigned hold_left = 0;
    int unsigned errors = 0;
    int unsigned n_load = 0, n_encode = 0, n_finish = 0, n_unused = 0;
    int unsigned n_bytes = 0, n_unknown = 0, n_results = 0;

    huffman_encoder_bit_packer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic push_req(input logic [1:0] cmd, input logic [7:0] sym,
                            input logic [15:0] cval, input logic [4:0] clen);
        hep_req_t r;
        begin
            r.cmd  = cmd;
            r.sym  = sym;
            r.cval = cval;
            r.clen = clen;
            stim_q = {stim_q, r};
            if (cmd != CMD_UNUSED)
                gen_count++;
            if (cmd == hep_pkg::CMD_LOAD && !gen_loaded[sym])
            begin
                gen_loaded[sym] = 1'b1;
                gen_syms = {gen_syms, sym};
            end
        end
    endtask

    // Random table load; symbols 0xF8..0xFF never get a code
    task automatic push_random_load();
        int pick;
        logic [4:0] len;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                len = 5'd0;
            else if (pick < 12)
                len = 5'($urandom_range(LEN_LIMIT + 1, 31));
            else
                len = 5'($urandom_range(1, LEN_LIMIT));
            push_req(hep_pkg::CMD_LOAD, 8'($urandom_range(0, 8'hF7)), 16'($urandom), len);
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: table writes, code packing and run flush
    // ------------------------------------------------------------------
    task automatic code_and_pack(input hep_req_t r);
        logic [63:0] acc;
        int unsigned len;
        int unsigned n;
        hep_pkg::res_t e;
        begin
            e = '0;
            case (r.cmd)
                hep_pkg::CMD_LOAD:
                begin
                    if (int'(r.sym) < hep_pkg::ALPHABET_SIZE_DEF)
                    begin
                        len = 32'(r.clen);
                        if (len > LEN_LIMIT)
                            len = LEN_LIMIT;
                        tbl_code[r.sym]  = r.cval;
                        tbl_len[r.sym]   = len;
                        tbl_valid[r.sym] = 1'b1;
                    end
                end
                hep_pkg::CMD_ENCODE:
                begin
                    if (int'(r.sym) >= hep_pkg::ALPHABET_SIZE_DEF || !tbl_valid[r.sym])
                    begin
                        e.unknown_symbol = 1'b1;
                        e.last = 1'b1;
                        coded_results_q = {coded_results_q, e};
                    end
                    else
                    begin
                        len = tbl_len[r.sym];
                        acc = (64'(run_bits) << len) |
                              (64'(tbl_code[r.sym]) & ((64'd1 << len) - 64'd1));
                        n = run_count + len;
                        // emit every full byte, earliest bit in the MSB
                        while (n >= 8)
                        begin
                            e = '0;
                            e.out_byte   = 8'(acc >> (n - 8));
                            e.byte_valid = 1'b1;
                            coded_results_q = {coded_results_q, e};
                            n -= 8;
                        end
                        run_bits  = 7'(acc & ((64'd1 << n) - 64'd1));
                        run_count = n;
                        if (run_total > 32'hFFFF_FFFF - len)
                            run_total = 32'hFFFF_FFFF;
                        else
                            run_total = run_total + len;
                    end
                end
                hep_pkg::CMD_FINISH:
                begin
                    if (run_count != 0)
                    begin
                        e.out_byte   = 8'({1'b0, run_bits} << (8 - run_count));
                        e.byte_valid = 1'b1;
                    end
                    e.last       = 1'b1;
                    e.total_bits = run_total;
                    coded_results_q = {coded_results_q, e};
                    run_bits  = '0;
                    run_count = 0;
                    run_total = '0;
                end
                default: ;
            endcase
        end
    endtask

    task automatic flag_mismatch(input string what, input hep_pkg::res_t e,
                                 input hep_pkg::res_t a);
        begin
            errors++;
            if (errors <= MAX_SHOWN)
            begin
                $display("[%0t] %s: exp byte=%02h bv=%0b unk=%0b last=%0b total=%0d",
                         $time, what, e.out_byte, e.byte_valid, e.unknown_symbol,
                         e.last, e.total_bits);
                $display("    got byte=%02h bv=%0b unk=%0b last=%0b total=%0d",
                         a.out_byte, a.byte_valid, a.unknown_symbol, a.last,
                         a.total_bits);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Cycle count and run limit
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle, coded_results_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                code_and_pack(cur_req);
                case (cur_req.cmd)
                    hep_pkg::CMD_LOAD:   n_load++;
                    hep_pkg::CMD_ENCODE: n_encode++;
                    hep_pkg::CMD_FINISH: n_finish++;
                    default:             n_unused++;
                endcase
            end
            // a request on the bus stays until taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (stim_q.size() != 0 &&
                    ((cycle inside {[QUIET_START:QUIET_END-1]}) ||
                     $urandom_range(0, 99) >= 25))
                begin
                    cur_req = stim_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, cur_req.clen, cur_req.cval, cur_req.sym};
                    s_axis_tuser  <= cur_req.cmd;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end
        else
        begin
            if (cycle == HOLD_START)
                hold_left <= HOLD_LEN;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
            m_axis_tready <= (cycle != HOLD_START) && (hold_left <= 1) &&
                             ((cycle inside {[QUIET_START:QUIET_END-1]}) ||
                              $urandom_range(0, 99) >= 25);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res.out_byte       = m_axis_tdata[7:0];
            got_res.total_bits     = m_axis_tdata[39:8];
            got_res.byte_valid     = m_axis_tuser[0];
            got_res.unknown_symbol = m_axis_tuser[1];
            got_res.last           = m_axis_tlast;
            n_results++;
            if (got_res.byte_valid === 1'b1)
                n_bytes++;
            if (got_res.unknown_symbol === 1'b1)
                n_unknown++;
            if (coded_results_q.size() == 0)
                flag_mismatch("unexpected result", '0, got_res);
            else
            begin
                exp_res = coded_results_q.pop_front();
                if (got_res.out_byte !== exp_res.out_byte ||
                    got_res.byte_valid !== exp_res.byte_valid ||
                    got_res.unknown_symbol !== exp_res.unknown_symbol ||
                    got_res.last !== exp_res.last ||
                    got_res.total_bits !== exp_res.total_bits)
                    flag_mismatch("result mismatch", exp_res, got_res);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int pick;
        int run_len;

        // symbol with no code yet, then an empty run
        push_req(hep_pkg::CMD_ENCODE, 8'h00, 16'h0000, 5'd0);
        push_req(hep_pkg::CMD_FINISH, 8'h00, 16'h0000, 5'd0);
        // table corners: empty code, all ones, over-long lengths
        push_req(hep_pkg::CMD_LOAD, 8'h41, 16'h0005, 5'd3);
        push_req(hep_pkg::CMD_LOAD, 8'h00, 16'hFFFF, 5'd0);
        push_req(hep_pkg::CMD_LOAD, 8'h7E, 16'hFFFF, 5'd16);
        push_req(hep_pkg::CMD_LOAD, 8'h81, 16'h0000, 5'd31);
        push_req(hep_pkg::CMD_LOAD, 8'h22, 16'hA5C3, 5'd17);
        push_req(hep_pkg::CMD_LOAD, 8'h10, 16'hFFFE, 5'd1);
        push_req(hep_pkg::CMD_LOAD, 8'h33, 16'h00C3, 5'd8);
        push_req(CMD_UNUSED, 8'hFF, 16'hFFFF, 5'd31);
        // two bytes from one symbol, zero-bit code, error mid-run, padded flush
        push_req(hep_pkg::CMD_ENCODE, 8'h41, 16'h0000, 5'd0);
        push_req(hep_pkg::CMD_ENCODE, 8'h7E, 16'h0000, 5'd0);
        push_req(hep_pkg::CMD_ENCODE, 8'h00, 16'h0000, 5'd0);
        push_req(hep_pkg::CMD_ENCODE, 8'hFF, 16'h0000, 5'd0);
        push_req(hep_pkg::CMD_FINISH, 8'h00, 16'h0000, 5'd0);
        // byte-aligned finish
        push_req(hep_pkg::CMD_ENCODE, 8'h33, 16'h0000, 5'd0);
        push_req(hep_pkg::CMD_FINISH, 8'h00, 16'h0000, 5'd0);
        // saturated lengths, then a single-bit code
        push_req(hep_pkg::CMD_ENCODE, 8'h81, 16'h0000, 5'd0);
        push_req(hep_pkg::CMD_ENCODE, 8'h22, 16'h0000, 5'd0);
        push_req(hep_pkg::CMD_ENCODE, 8'h10, 16'h0000, 5'd0);
        push_req(hep_pkg::CMD_FINISH, 8'h00, 16'h0000, 5'd0);

        // random part: mostly encode runs closed by a finish
        while (gen_count < RANDOM_REQS + 21)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 14)
                push_random_load();
            else if (pick < 17)
                push_req(CMD_UNUSED, 8'($urandom), 16'($urandom), 5'($urandom));
            else if (pick < 21)
                push_req(hep_pkg::CMD_ENCODE, 8'($urandom_range(8'hF8, 8'hFF)),
                         16'($urandom), 5'($urandom));
            else
            begin
                run_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                repeat (run_len)
                    push_req(hep_pkg::CMD_ENCODE,
                             gen_syms[$urandom_range(0, gen_syms.size() - 1)],
                             16'($urandom), 5'($urandom));
                push_req(hep_pkg::CMD_FINISH, 8'($urandom), 16'($urandom), 5'($urandom));
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (coded_results_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Requests: %0d loads, %0d encodes, %0d finishes, %0d unused commands",
                 n_load, n_encode, n_finish, n_unused);
        $display("Results: %0d checked, %0d packed bytes, %0d unknown symbols, %0d mismatches",
                 n_results, n_bytes, n_unknown, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
